FILE: sv/dfr_pkg.sv
// dfr_pkg: shared widths, codes and controller/datapath interface structs
// for the DDS frequency ramp unit. No dependencies.
package dfr_pkg;

  localparam int FREQ_W  = 31;
  localparam int DUR_W   = 32;
  localparam int CLK_W   = 32;
  localparam int WORD_W  = 28;
  localparam int OP_W    = 2;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int DIVD_W  = 64;
  localparam int DIVS_W  = 32;

  localparam logic [CLK_W-1:0] CLOCK_RESET_HZ = 32'd75000000;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
  localparam logic [OP_W-1:0] OP_SET   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MCLK   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'd1;

  typedef struct packed {
    logic capture;
    logic apply_ctl;
    logic inc_elapsed;
    logic take_goal;
    logic take_set;
    logic mul;
    logic div_frac;
    logic add;
    logic div_word;
    logic load_out;
  } dfr_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            running;
    logic            at_end;
    logic            div_done;
    logic            out_free;
  } dfr_status_t;

endpackage

FILE: sv/dfr_divider.sv
// dfr_divider: restoring radix-2 divider, one quotient bit per cycle.
// 64-bit dividend over 32-bit divisor. Uses dfr_pkg.
module dfr_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dfr_pkg::DIVD_W-1:0]    dividend,
  input  logic [dfr_pkg::DIVS_W-1:0]    divisor,
  output logic [dfr_pkg::DIVD_W-1:0]    quotient,
  output logic                          done
);

  localparam int CNT_W = $clog2(dfr_pkg::DIVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(dfr_pkg::DIVD_W - 1);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [dfr_pkg::DIVS_W-1:0]   rem_r, rem_nxt;
  logic [dfr_pkg::DIVD_W-1:0]   quo_r, quo_nxt;
  logic [dfr_pkg::DIVS_W-1:0]   den_r, den_nxt;
  logic [dfr_pkg::DIVS_W:0]     shifted;
  logic [dfr_pkg::DIVS_W:0]     den_ext;
  logic                         ge;

  assign shifted = {rem_r, quo_r[dfr_pkg::DIVD_W-1]};
  assign den_ext = {1'b0, den_r};
  assign ge      = shifted >= den_ext;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? dfr_pkg::DIVS_W'(shifted - den_ext) : shifted[dfr_pkg::DIVS_W-1:0];
      quo_nxt = {quo_r[dfr_pkg::DIVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: sv/dfr_datapath.sv
// dfr_datapath: ramp state, config registers, multiplier, shared divider
// and result register. Uses dfr_pkg and dfr_divider.
module dfr_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dfr_pkg::dfr_cmd_t                 cmd,
  output dfr_pkg::dfr_status_t              status,
  input  logic                              cfg_write_en,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dfr_pkg::CFG_W-1:0]         cfg_data,
  input  logic [dfr_pkg::OP_W-1:0]          in_operation,
  input  logic [dfr_pkg::FREQ_W-1:0]        in_frequency_hz,
  input  logic [dfr_pkg::DUR_W-1:0]         in_duration_ms,
  input  logic                              in_register_select,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_write_valid,
  output logic                              out_register_index,
  output logic [dfr_pkg::FREQ_W-1:0]        out_written_frequency,
  output logic [dfr_pkg::WORD_W-1:0]        out_tuning_word,
  output logic                              out_ramp_busy
);

  localparam int PAD_W = dfr_pkg::DIVD_W - dfr_pkg::FREQ_W - dfr_pkg::WORD_W;

  logic [dfr_pkg::CLK_W-1:0]   mclk_r;
  logic                        active_r;
  logic [dfr_pkg::FREQ_W-1:0]  stored_r [2];
  logic                        running_r;
  logic [dfr_pkg::FREQ_W-1:0]  origin_r, goal_r;
  logic [dfr_pkg::DUR_W-1:0]   length_r, elapsed_r;

  logic [dfr_pkg::OP_W-1:0]    op_r;
  logic [dfr_pkg::FREQ_W-1:0]  freq_in_r;
  logic [dfr_pkg::DUR_W-1:0]   dur_in_r;
  logic                        sel_in_r;

  logic [dfr_pkg::FREQ_W-1:0]  f_r;
  logic                        reg_r;
  logic                        wr_r;
  logic [dfr_pkg::DIVD_W-1:0]  prod_r;

  logic                        out_valid_r;
  logic                        out_wv_r, out_idx_r, out_busy_r;
  logic [dfr_pkg::FREQ_W-1:0]  out_freq_r;
  logic [dfr_pkg::WORD_W-1:0]  out_tw_r;

  logic                        up;
  logic [dfr_pkg::FREQ_W-1:0]  mag;
  logic [dfr_pkg::CLK_W-1:0]   mclk_eff;
  logic                        div_start, div_done;
  logic [dfr_pkg::DIVD_W-1:0]  div_dividend, div_quotient;
  logic [dfr_pkg::DIVS_W-1:0]  div_divisor;
  logic [dfr_pkg::FREQ_W-1:0]  q_frac;

  assign up       = goal_r >= origin_r;
  assign mag      = up ? (goal_r - origin_r) : (origin_r - goal_r);
  assign mclk_eff = (mclk_r == '0) ? dfr_pkg::CLOCK_RESET_HZ : mclk_r;
  assign q_frac   = div_quotient[dfr_pkg::FREQ_W-1:0];

  assign div_start    = cmd.div_frac | cmd.div_word;
  assign div_dividend = cmd.div_frac ? prod_r : {{PAD_W{1'b0}}, f_r, {dfr_pkg::WORD_W{1'b0}}};
  assign div_divisor  = cmd.div_frac ? length_r : mclk_eff;

  dfr_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // config and ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mclk_r      <= dfr_pkg::CLOCK_RESET_HZ;
      active_r    <= 1'b0;
      stored_r[0] <= '0;
      stored_r[1] <= '0;
      running_r   <= 1'b0;
      origin_r    <= '0;
      goal_r      <= '0;
      length_r    <= '0;
      elapsed_r   <= '0;
      wr_r        <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == dfr_pkg::CFG_MCLK) mclk_r <= cfg_data;
        if (cfg_index == dfr_pkg::CFG_ACTIVE) active_r <= cfg_data[0];
      end
      if (cmd.capture) wr_r <= 1'b0;
      if (cmd.apply_ctl) begin
        if (op_r == dfr_pkg::OP_START) begin
          origin_r  <= stored_r[active_r];
          goal_r    <= freq_in_r;
          length_r  <= dur_in_r;
          elapsed_r <= '0;
          running_r <= 1'b1;
        end else if (op_r == dfr_pkg::OP_STOP) begin
          running_r <= 1'b0;
        end
      end
      if (cmd.inc_elapsed && (elapsed_r != '1)) elapsed_r <= elapsed_r + 1'b1;
      if (cmd.take_goal) begin
        running_r <= 1'b0;
        wr_r      <= 1'b1;
      end
      if (cmd.take_set || cmd.add) wr_r <= 1'b1;
      if (cmd.load_out && wr_r) stored_r[reg_r] <= f_r;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_operation;
      freq_in_r <= in_frequency_hz;
      dur_in_r  <= in_duration_ms;
      sel_in_r  <= in_register_select;
    end
    if (cmd.inc_elapsed) reg_r <= active_r;
    if (cmd.take_set) begin
      f_r   <= freq_in_r;
      reg_r <= sel_in_r;
    end
    if (cmd.take_goal) f_r <= goal_r;
    if (cmd.add) f_r <= up ? (origin_r + q_frac) : (origin_r - q_frac);
    if (cmd.mul) prod_r <= dfr_pkg::DIVD_W'(mag) * dfr_pkg::DIVD_W'(elapsed_r);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_wv_r   <= wr_r;
      out_idx_r  <= wr_r & reg_r;
      out_freq_r <= wr_r ? f_r : '0;
      out_tw_r   <= wr_r ? div_quotient[dfr_pkg::WORD_W-1:0] : '0;
      out_busy_r <= running_r;
    end
  end

  assign status.op       = op_r;
  assign status.running  = running_r;
  assign status.at_end   = elapsed_r >= length_r;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid             = out_valid_r;
  assign out_write_valid       = out_wv_r;
  assign out_register_index    = out_idx_r;
  assign out_written_frequency = out_freq_r;
  assign out_tuning_word       = out_tw_r;
  assign out_ramp_busy         = out_busy_r;

endmodule

FILE: sv/dfr_ctrl.sv
// dfr_ctrl: sequencer for the ramp unit; issues datapath commands per word.
// Uses dfr_pkg.
module dfr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dfr_pkg::dfr_status_t  status,
  output dfr_pkg::dfr_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_CHECK   = 3'd2;
  localparam logic [2:0] S_MUL     = 3'd3;
  localparam logic [2:0] S_FRAC    = 3'd4;
  localparam logic [2:0] S_WORD_GO = 3'd5;
  localparam logic [2:0] S_WORD    = 3'd6;
  localparam logic [2:0] S_FINISH  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if ((status.op == dfr_pkg::OP_TICK) && status.running) begin
          cmd.inc_elapsed = 1'b1;
          state_nxt       = S_CHECK;
        end else if (status.op == dfr_pkg::OP_SET) begin
          cmd.take_set = 1'b1;
          state_nxt    = S_WORD_GO;
        end else begin
          cmd.apply_ctl = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_CHECK: begin
        if (status.at_end) begin
          cmd.take_goal = 1'b1;
          state_nxt     = S_WORD_GO;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div_frac = 1'b1;
        state_nxt    = S_FRAC;
      end
      S_FRAC: begin
        if (status.div_done) begin
          cmd.add   = 1'b1;
          state_nxt = S_WORD_GO;
        end
      end
      S_WORD_GO: begin
        cmd.div_word = 1'b1;
        state_nxt    = S_WORD;
      end
      S_WORD: begin
        if (status.div_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

FILE: sv/dds_frequency_ramp_unit.sv
// dds_frequency_ramp_unit: top level of the DDS linear frequency ramp.
// Joins dfr_ctrl and dfr_datapath; uses dfr_pkg.
//
// Input channel (in_*): one word per operation: tick, start ramp, stop ramp
// or direct set. Output channel (out_*): exactly one result word per input
// word, in order. Config port (cfg_*): master clock (index 0) and active
// register (index 1), written while the unit is idle.
// One word is processed at a time; in_stall is high from acceptance until
// the result is loaded into the output register.
// Start, stop and idle tick go straight to the result load; a direct set,
// a ramp end and an interpolating tick use the shared radix-2 divider, once
// for the tuning word and, for an interpolating tick, once before that for
// the interpolation step. A new word is taken the cycle after the load, so
// no new word is taken before the last word's result is loaded.
// The next word is accepted while the previous result still waits in the
// output register; a stalled receiver only holds the unit in its last
// step until the output register frees.
// Synchronous reset clears ramp state, stored frequencies and config to
// their reset values; the unit is ready the cycle after reset.
module dds_frequency_ramp_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_write_en,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dfr_pkg::OP_W-1:0]        in_operation,
  input  logic [dfr_pkg::FREQ_W-1:0]      in_frequency_hz,
  input  logic [dfr_pkg::DUR_W-1:0]       in_duration_ms,
  input  logic                            in_register_select,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_write_valid,
  output logic                            out_register_index,
  output logic [dfr_pkg::FREQ_W-1:0]      out_written_frequency,
  output logic [dfr_pkg::WORD_W-1:0]      out_tuning_word,
  output logic                            out_ramp_busy
);

  dfr_pkg::dfr_cmd_t    cmd;
  dfr_pkg::dfr_status_t status;

  dfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dfr_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .cfg_write_en          (cfg_write_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_operation          (in_operation),
    .in_frequency_hz       (in_frequency_hz),
    .in_duration_ms        (in_duration_ms),
    .in_register_select    (in_register_select),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_write_valid       (out_write_valid),
    .out_register_index    (out_register_index),
    .out_written_frequency (out_written_frequency),
    .out_tuning_word       (out_tuning_word),
    .out_ramp_busy         (out_ramp_busy)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("unit ready right after accepting a word");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |->
      (out_tuning_word == '0) && (out_written_frequency == '0) && !out_register_index)
    else $error("result without write carries nonzero fields");

  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("unit returned to ready without a result");
`endif

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking testbench for dds_frequency_ramp_unit.
// Drives tick/start/stop/set words with bursty traffic against a stalling receiver, predicts
// every result word in-line and compares field by field; depends on dfr_pkg and the unit RTL.
module tb_top;
  import dfr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 150;
  localparam int LONG_HOLD   = 600;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 116;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
    logic              sel;
  } ramp_cmd_t;

  typedef struct packed {
    logic              wr;
    logic              idx;
    logic [FREQ_W-1:0] freq;
    logic [WORD_W-1:0] word;
    logic              busy;
  } tune_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_operation = '0;
  logic [FREQ_W-1:0]    in_frequency_hz = '0;
  logic [DUR_W-1:0]     in_duration_ms = '0;
  logic                 in_register_select = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_write_valid;
  logic                 out_register_index;
  logic [FREQ_W-1:0]    out_written_frequency;
  logic [WORD_W-1:0]    out_tuning_word;
  logic                 out_ramp_busy;

  dds_frequency_ramp_unit u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_write_en          (cfg_write_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_frequency_hz       (in_frequency_hz),
    .in_duration_ms        (in_duration_ms),
    .in_register_select    (in_register_select),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_write_valid       (out_write_valid),
    .out_register_index    (out_register_index),
    .out_written_frequency (out_written_frequency),
    .out_tuning_word       (out_tuning_word),
    .out_ramp_busy         (out_ramp_busy)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state and its copy of the config registers
  logic [CLK_W-1:0]  cfg_mclk = CLOCK_RESET_HZ;
  logic              cfg_active = 1'b0;
  logic [FREQ_W-1:0] stored_freq [2];
  logic              sweep_on = 1'b0;
  logic [FREQ_W-1:0] sweep_origin = '0;
  logic [FREQ_W-1:0] sweep_goal = '0;
  logic [DUR_W-1:0]  sweep_len = '0;
  logic [DUR_W-1:0]  sweep_elapsed = '0;

  ramp_cmd_t    op_pending_q [$];
  tune_result_t expected_writes [$];

  int err_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int ramp_ends = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int burst_left = 1;
  int hold_req = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  function automatic logic [WORD_W-1:0] tuning_of(input logic [FREQ_W-1:0] f);
    logic [63:0] divisor;
    logic [63:0] scaled;
    divisor = (cfg_mclk == '0) ? {32'b0, CLOCK_RESET_HZ} : {32'b0, cfg_mclk};
    scaled  = {33'b0, f} << 28;
    scaled  = scaled / divisor;
    return scaled[WORD_W-1:0];
  endfunction

  task automatic emit_write(input logic sel, input logic [FREQ_W-1:0] f,
                            inout tune_result_t r);
    stored_freq[sel] = f;
    r.wr   = 1'b1;
    r.idx  = sel;
    r.freq = f;
    r.word = tuning_of(f);
  endtask

  task automatic ramp_predict(input ramp_cmd_t c);
    tune_result_t      r;
    logic [63:0]       span;
    logic [63:0]       step;
    logic [FREQ_W-1:0] f;
    r = '0;
    case (c.op)
      OP_TICK: begin
        if (sweep_on) begin
          if (sweep_elapsed != 32'hFFFF_FFFF) sweep_elapsed = sweep_elapsed + 1;
          if (sweep_elapsed >= sweep_len) begin
            f = sweep_goal;
            sweep_on = 1'b0;
            ramp_ends++;
          end else begin
            if (sweep_goal >= sweep_origin) span = {33'b0, sweep_goal} - {33'b0, sweep_origin};
            else span = {33'b0, sweep_origin} - {33'b0, sweep_goal};
            step = (span * {32'b0, sweep_elapsed}) / {32'b0, sweep_len};
            f = (sweep_goal >= sweep_origin) ? sweep_origin + step[FREQ_W-1:0]
                                             : sweep_origin - step[FREQ_W-1:0];
          end
          emit_write(cfg_active, f, r);
        end
      end
      OP_START: begin
        sweep_origin  = stored_freq[cfg_active];
        sweep_goal    = c.freq;
        sweep_len     = c.dur;
        sweep_elapsed = '0;
        sweep_on      = 1'b1;
      end
      OP_STOP: sweep_on = 1'b0;
      default: emit_write(c.sel, c.freq, r);
    endcase
    r.busy = sweep_on;
    expected_writes.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      err_count++;
    end
  endtask

  // driver: bursts of words from the pending queue with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ramp_predict(op_pending_q[0]);
        op_pending_q.delete(0);
        words_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_pending_q.size() != 0) begin
          in_valid           <= 1'b1;
          in_operation       <= op_pending_q[0].op;
          in_frequency_hz    <= op_pending_q[0].freq;
          in_duration_ms     <= op_pending_q[0].dur;
          in_register_select <= op_pending_q[0].sel;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_served != hold_req) begin
        hold_served = hold_req;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(20, 300);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tune_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_writes.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        err_count++;
      end else begin
        want = expected_writes.pop_front();
        check_field("write_valid", 32'(want.wr), 32'(out_write_valid));
        check_field("register_index", 32'(want.idx), 32'(out_register_index));
        check_field("written_frequency", 32'(want.freq), 32'(out_written_frequency));
        check_field("tuning_word", 32'(want.word), 32'(out_tuning_word));
        check_field("ramp_busy", 32'(want.busy), 32'(out_ramp_busy));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: timeout at cycle %0d", cycle_cnt);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [FREQ_W-1:0] f,
                          input logic [DUR_W-1:0] d, input logic s);
    ramp_cmd_t c;
    c.op   = op;
    c.freq = f;
    c.dur  = d;
    c.sel  = s;
    op_pending_q.push_back(c);
  endtask

  function automatic logic [FREQ_W-1:0] rnd_freq();
    logic [31:0] t;
    t = $urandom();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2:       t = $urandom_range(0, 100000);
      default: ;
    endcase
    return t[FREQ_W-1:0];
  endfunction

  function automatic logic [DUR_W-1:0] rnd_len();
    case ($urandom_range(0, 9))
      0:       return 32'hFFFF_FFFF;
      1:       return $urandom();
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic logic rnd_bit();
    logic [31:0] t;
    t = $urandom();
    return t[0];
  endfunction

  function automatic logic [OP_W-1:0] rnd_op();
    logic [31:0] t;
    t = $urandom();
    return t[OP_W-1:0];
  endfunction

  // mostly well-formed ramps: a start, ticks through (or past) a short length or into a long one, some
  // sets, stops and restarts mixed in; the rest is random noise
  task automatic gen_traffic(input int n);
    int          made;
    int          ticks;
    int          k;
    logic [31:0] d;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 3) != 0) begin
        d = rnd_len();
        push_cmd(OP_START, rnd_freq(), d, rnd_bit());
        ticks = (d < 16) ? int'(d) + $urandom_range(0, 2) : $urandom_range(1, 16);
        for (k = 0; k < ticks; k++) begin
          case ($urandom_range(0, 29))
            0, 1:    push_cmd(OP_SET, rnd_freq(), $urandom(), rnd_bit());
            2:       push_cmd(OP_STOP, rnd_freq(), $urandom(), rnd_bit());
            3:       push_cmd(OP_START, rnd_freq(), rnd_len(), rnd_bit());
            default: push_cmd(OP_TICK, rnd_freq(), $urandom(), rnd_bit());
          endcase
        end
        made += ticks + 1;
      end else begin
        push_cmd(rnd_op(), rnd_freq(), rnd_len(), rnd_bit());
        made++;
      end
    end
  endtask

  task automatic drain_block();
    while (op_pending_q.size() != 0 || expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_MCLK:   cfg_mclk = data;
      CFG_ACTIVE: cfg_active = data[0];
      default:    ;
    endcase
    cfg_writes++;
  endtask

  initial begin
    int          ph;
    logic [31:0] mclk;
    stored_freq[0] = '0;
    stored_freq[1] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, set extremes, idle stop, zero-length ramp, restart
    // while running, set during a ramp, stop, very long ramp, active switch
    push_cmd(OP_TICK, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_cmd(OP_SET, 31'h7FFF_FFFF, 32'd0, 1'b0);
    push_cmd(OP_SET, 31'd0, 32'hFFFF_FFFF, 1'b1);
    push_cmd(OP_STOP, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_START, 31'd1000, 32'd0, 1'b1);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_START, 31'h7FFF_FFFF, 32'd3, 1'b0);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_SET, 31'd12345, 32'd0, 1'b1);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_START, 31'd0, 32'd5, 1'b0);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_STOP, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_START, 31'd5, 32'hFFFF_FFFF, 1'b0);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    drain_block();
    write_reg(CFG_ACTIVE, 32'd1);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_SET, 31'h4000_0000, 32'd0, 1'b0);
    push_cmd(OP_START, 31'h7FFF_FFFF, 32'd2, 1'b0);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    push_cmd(OP_TICK, 31'd0, 32'd0, 1'b0);
    drain_block();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       mclk = CLOCK_RESET_HZ;
        1:       mclk = 32'd1;
        2:       mclk = 32'hFFFF_FFFF;
        3:       mclk = 32'd0;
        4:       mclk = $urandom_range(2, 1000);
        default: mclk = $urandom();
      endcase
      write_reg(CFG_MCLK, mclk);
      write_reg(CFG_ACTIVE, (ph % 2 == 0) ? 32'd0 : 32'd1);
      if (ph == 2) hold_req++;
      if (ph == 5) begin
        gen_traffic(PHASE_WORDS / 2);
        drain_block();
        gen_traffic(PHASE_WORDS / 2);
      end else begin
        gen_traffic(PHASE_WORDS);
      end
      drain_block();
    end

    $display("tb_top: %0d words, %0d results checked, %0d register writes, %0d ramp ends",
             words_sent, results_checked, cfg_writes, ramp_ends);
    if (err_count == 0 && expected_writes.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: dds_frequency_ramp_unit.f
sv/dfr_pkg.sv
sv/dfr_divider.sv
sv/dfr_datapath.sv
sv/dfr_ctrl.sv
sv/dds_frequency_ramp_unit.sv
sim/tb_top.sv
